// ----- hw/rtl/zrc_pkg.sv -----
// ----------------------------------------------------------------------------
// zrc_pkg
// Shared types and constants of the zero-run word compressor.
// ----------------------------------------------------------------------------
package zrc_pkg;

  localparam int WORD_BITS_DEF        = 32;
  localparam int MAX_SOURCE_WORDS_DEF = 65535;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 17;
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int BEAT_W  = $clog2(MAX_RES);

  localparam logic [ADDR_W-1:0] IDX_MAX = 17'h1FFFF;
  localparam logic [ADDR_W-1:0] TGT_MAX = 17'h10000;
  localparam logic [15:0]       LEN_MAX = 16'hFFFF;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              final_res;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
    logic               overflow;
  } pkt_t;

endpackage

// ----- hw/rtl/zrc_if.sv -----
// ----------------------------------------------------------------------------
// zrc_in_if / zrc_out_if
// Valid/ready channels for source words and for result beats.
// ----------------------------------------------------------------------------
interface zrc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last;

  modport source (output valid, word, last, input ready);
  modport sink   (input valid, word, last, output ready);
endinterface

interface zrc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [16:0] address;
  logic [31:0] data;
  logic        overflow;
  logic        final_res;

  modport source (output valid, kind, address, data, overflow, final_res, input ready);
  modport sink   (input valid, kind, address, data, overflow, final_res, output ready);
endinterface

// ----- hw/rtl/zrc_front.sv -----
// ----------------------------------------------------------------------------
// zrc_front
// Accepts source words, tracks run state and builds the result packet of
// each word.
// ----------------------------------------------------------------------------
module zrc_front #(
  parameter int WORD_BITS        = zrc_pkg::WORD_BITS_DEF,
  parameter int MAX_SOURCE_WORDS = zrc_pkg::MAX_SOURCE_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  zrc_in_if.sink        in_ch,
  input  logic          q_ready,
  output logic          q_push,
  output zrc_pkg::pkt_t q_pkt
);

  localparam logic [31:0] WORD_MASK =
    (WORD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << WORD_BITS) - 64'd1);
  localparam logic [zrc_pkg::ADDR_W-1:0] MAX_SRC = zrc_pkg::ADDR_W'(MAX_SOURCE_WORDS);

  logic                        in_run_r, in_run_nxt;
  logic                        zp_r, zp_nxt;
  logic [zrc_pkg::ADDR_W-1:0]  si_r, si_nxt;
  logic [zrc_pkg::ADDR_W-1:0]  ti_r, ti_nxt;
  logic [zrc_pkg::ADDR_W-1:0]  ha_r, ha_nxt;
  logic [15:0]                 rs_r, rs_nxt;
  logic [15:0]                 rl_r, rl_nxt;
  logic                        ov_r, ov_nxt;
  logic [31:0]                 w;
  logic                        nz;
  logic                        acc;
  zrc_pkg::pkt_t               pkt;

  function automatic logic [zrc_pkg::ADDR_W-1:0] inc_tgt(input logic [zrc_pkg::ADDR_W-1:0] x);
    inc_tgt = (x < zrc_pkg::TGT_MAX) ? x + 17'd1 : x;
  endfunction

  function automatic logic [15:0] inc_len(input logic [15:0] x);
    inc_len = (x < zrc_pkg::LEN_MAX) ? x + 16'd1 : x;
  endfunction

  assign in_ch.ready = q_ready;
  assign acc         = in_ch.valid && q_ready;
  assign w           = in_ch.word & WORD_MASK;
  assign nz          = (w != 32'd0);

  always_comb begin
    logic [zrc_pkg::CNT_W-1:0] n;
    logic                      ov;
    n          = '0;
    pkt        = '0;
    in_run_nxt = in_run_r;
    zp_nxt     = zp_r;
    ti_nxt     = ti_r;
    ha_nxt     = ha_r;
    rs_nxt     = rs_r;
    rl_nxt     = rl_r;
    ov         = ov_r | (si_r >= MAX_SRC);
    si_nxt     = (si_r < zrc_pkg::IDX_MAX) ? si_r + 17'd1 : si_r;

    if (!in_run_r) begin
      if (nz) begin
        in_run_nxt = 1'b1;
        zp_nxt     = 1'b0;
        ha_nxt     = ti_r;
        rs_nxt     = si_r[15:0];
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] = '{zrc_pkg::KIND_WRITE, inc_tgt(ti_r), w, 1'b0};
        n      = n + 1'b1;
        ti_nxt = inc_tgt(inc_tgt(ti_r));
        rl_nxt = 16'd1;
      end
    end else if (zp_r) begin
      if (!nz) begin
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] =
          '{zrc_pkg::KIND_WRITE, ha_r, {rl_r, rs_r}, 1'b0};
        n          = n + 1'b1;
        in_run_nxt = 1'b0;
        zp_nxt     = 1'b0;
      end else begin
        zp_nxt = 1'b0;
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] = '{zrc_pkg::KIND_WRITE, ti_r, 32'd0, 1'b0};
        n = n + 1'b1;
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] = '{zrc_pkg::KIND_WRITE, inc_tgt(ti_r), w, 1'b0};
        n      = n + 1'b1;
        ti_nxt = inc_tgt(inc_tgt(ti_r));
        rl_nxt = inc_len(inc_len(rl_r));
      end
    end else if (nz || in_ch.last) begin
      pkt.res[n[zrc_pkg::BEAT_W-1:0]] = '{zrc_pkg::KIND_WRITE, ti_r, w, 1'b0};
      n      = n + 1'b1;
      ti_nxt = inc_tgt(ti_r);
      rl_nxt = inc_len(rl_r);
    end else begin
      zp_nxt = 1'b1;
    end

    if (in_ch.last) begin
      if (in_run_nxt) begin
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] =
          '{zrc_pkg::KIND_WRITE, ha_nxt, {rl_nxt, rs_nxt}, 1'b0};
        n = n + 1'b1;
      end
      if (ti_nxt == '0) begin
        pkt.res[n[zrc_pkg::BEAT_W-1:0]] = '{zrc_pkg::KIND_WRITE, '0, 32'd0, 1'b0};
        n = n + 1'b1;
      end
      pkt.res[n[zrc_pkg::BEAT_W-1:0]] =
        '{zrc_pkg::KIND_DONE, '0, {15'd0, ti_nxt}, 1'b1};
      n          = n + 1'b1;
      in_run_nxt = 1'b0;
      zp_nxt     = 1'b0;
      si_nxt     = '0;
      ti_nxt     = '0;
      ha_nxt     = '0;
      rs_nxt     = '0;
      rl_nxt     = '0;
      ov_nxt     = 1'b0;
    end else begin
      ov_nxt = ov;
    end

    pkt.cnt      = n;
    pkt.overflow = ov;
  end

  assign q_push = acc && (pkt.cnt != '0);
  assign q_pkt  = pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
      zp_r     <= 1'b0;
      si_r     <= '0;
      ti_r     <= '0;
      ha_r     <= '0;
      rs_r     <= '0;
      rl_r     <= '0;
      ov_r     <= 1'b0;
    end else if (acc) begin
      in_run_r <= in_run_nxt;
      zp_r     <= zp_nxt;
      si_r     <= si_nxt;
      ti_r     <= ti_nxt;
      ha_r     <= ha_nxt;
      rs_r     <= rs_nxt;
      rl_r     <= rl_nxt;
      ov_r     <= ov_nxt;
    end
  end

`ifndef SYNTH
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.last) |=> (!in_run_r && !zp_r && ti_r == '0 && si_r == '0))
    else $error("state not cleared after last word");

  a_mid_stream_beats: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !in_ch.last) |-> (q_pkt.cnt <= zrc_pkg::CNT_W'(2)))
    else $error("too many beats for a word inside the stream");
`endif

endmodule

// ----- hw/rtl/zrc_queue.sv -----
// ----------------------------------------------------------------------------
// zrc_queue
// Short packet queue between the classifying front and the beat sequencer.
// ----------------------------------------------------------------------------
module zrc_queue #(
  parameter int DEPTH = zrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zrc_pkg::pkt_t push_pkt,
  output logic          not_full,
  input  logic          pop,
  output logic          head_valid,
  output zrc_pkg::pkt_t head_pkt
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  zrc_pkg::pkt_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign not_full   = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_pkt   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CW'(DEPTH)) && !(push && !not_full) && !(pop && !head_valid))
    else $error("queue overrun or underrun");
`endif

endmodule

// ----- hw/rtl/zrc_back.sv -----
// ----------------------------------------------------------------------------
// zrc_back
// Walks each queued packet and sends its results one beat at a time.
// ----------------------------------------------------------------------------
module zrc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  zrc_pkg::pkt_t q_pkt,
  output logic          q_pop,
  zrc_out_if.source     out_ch
);

  logic [zrc_pkg::BEAT_W-1:0] beat_r;
  logic                       out_valid_r;
  zrc_pkg::res_t              out_res_r;
  logic                       out_ov_r;
  logic                       load;
  logic                       last_beat;

  assign load      = q_valid && (!out_valid_r || out_ch.ready);
  assign last_beat = ({1'b0, beat_r} == (q_pkt.cnt - 1'b1));
  assign q_pop     = load && last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        beat_r      <= last_beat ? '0 : beat_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= q_pkt.res[beat_r];
      out_ov_r  <= q_pkt.overflow;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_res_r.kind;
  assign out_ch.address   = out_res_r.address;
  assign out_ch.data      = out_res_r.data;
  assign out_ch.overflow  = out_ov_r;
  assign out_ch.final_res = out_res_r.final_res;

`ifndef SYNTH
  a_final_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.final_res) |-> (out_res_r.kind == zrc_pkg::KIND_DONE))
    else $error("final beat is not a done result");
`endif

endmodule

// ----- hw/rtl/zero_run_word_compressor_unit.sv -----
// ----------------------------------------------------------------------------
// zero_run_word_compressor_unit
// Zero-run word compressor: source words in, target-memory writes and a
// done beat with the total target size out.
// ----------------------------------------------------------------------------
// The unit accepts one source word per cycle while the queue has room and
// sends one result beat per cycle while the output is ready. The front
// classifies each word in the cycle it is accepted and queues its zero to
// four result beats as one packet; the back sends them one by one from an
// output register that it loads from the queue memory. Inside a stream a
// word makes at most two beats and never more than one per word on average,
// so the packet queue (QUEUE_DEPTH packets) absorbs the bursts; input stalls
// when the queue fills behind a stalled output, or behind the up to four
// beats that close each stream when short streams follow one another.
module zero_run_word_compressor_unit #(
  parameter int WORD_BITS        = zrc_pkg::WORD_BITS_DEF,
  parameter int MAX_SOURCE_WORDS = zrc_pkg::MAX_SOURCE_WORDS_DEF,
  parameter int QUEUE_DEPTH      = zrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  zrc_in_if.sink    in_ch,
  zrc_out_if.source out_ch
);

  logic          push, not_full, pop, head_valid;
  zrc_pkg::pkt_t push_pkt, head_pkt;

  zrc_front #(
    .WORD_BITS        (WORD_BITS),
    .MAX_SOURCE_WORDS (MAX_SOURCE_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (not_full),
    .q_push  (push),
    .q_pkt   (push_pkt)
  );

  zrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_pkt   (push_pkt),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_pkt   (head_pkt)
  );

  zrc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (head_valid),
    .q_pkt   (head_pkt),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
